// File: rtl/otl_pkg.sv
`default_nettype none

package otl_pkg;

    // Command codes carried on the input channel
    localparam logic [1:0] CMD_INSERT_TAIL = 2'd0;
    localparam logic [1:0] CMD_INSERT_HEAD = 2'd1;
    localparam logic [1:0] CMD_REMOVE_HEAD = 2'd2;
    localparam logic [1:0] CMD_REMOVE_KEY  = 2'd3;

    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 48;
    localparam int COUNT_W = 5;

    // Per-cycle operation broadcast to every cell of the table
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_TAIL,
        CELL_SHIFT_R,
        CELL_SHIFT_L
    } cell_op_t;

    // Contents of one table slot, also what moves between neighbors
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] start;
    } cell_data_t;

endpackage

`default_nettype wire

// File: rtl/otl_cell.sv
`default_nettype none

module otl_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire otl_pkg::cell_op_t              op,
    input  wire logic                           shl_en,
    input  wire logic [otl_pkg::KEY_W-1:0]      new_key,
    input  wire logic [otl_pkg::TIME_W-1:0]     new_start,
    input  wire logic [otl_pkg::KEY_W-1:0]      search_key,
    input  wire otl_pkg::cell_data_t            left,
    input  wire otl_pkg::cell_data_t            right,
    output otl_pkg::cell_data_t                 q,
    output logic                                hit
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [otl_pkg::KEY_W-1:0]   key_reg;
    logic [otl_pkg::KEY_W-1:0]   key_next;
    logic [otl_pkg::TIME_W-1:0]  start_reg;
    logic [otl_pkg::TIME_W-1:0]  start_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        start_next = start_reg;
        unique case (op)
            otl_pkg::CELL_HOLD:
            begin
            end
            otl_pkg::CELL_LOAD_TAIL:
            begin
                // first empty slot: empty here, occupied on the left
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    key_next   = new_key;
                    start_next = new_start;
                end
            end
            otl_pkg::CELL_SHIFT_R:
            begin
                valid_next = left.valid;
                key_next   = left.key;
                start_next = left.start;
            end
            otl_pkg::CELL_SHIFT_L:
            begin
                if (shl_en)
                begin
                    valid_next = right.valid;
                    key_next   = right.key;
                    start_next = right.start;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        start_reg <= start_next;
    end

    assign q.valid = valid_reg;
    assign q.key   = key_reg;
    assign q.start = start_reg;
    assign hit     = valid_reg && (key_reg == search_key);

endmodule

`default_nettype wire

// File: rtl/otl_stats.sv
`default_nettype none

module otl_stats (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          update,
    input  wire logic [otl_pkg::TIME_W-1:0]    lat,
    output logic      [otl_pkg::SUM_W-1:0]     total,
    output logic      [otl_pkg::TIME_W-1:0]    min_lat,
    output logic      [otl_pkg::TIME_W-1:0]    max_lat
);

    logic [otl_pkg::SUM_W-1:0]   sum_reg;
    logic [otl_pkg::SUM_W-1:0]   sum_next;
    logic [otl_pkg::TIME_W-1:0]  min_reg;
    logic [otl_pkg::TIME_W-1:0]  min_next;
    logic [otl_pkg::TIME_W-1:0]  max_reg;
    logic [otl_pkg::TIME_W-1:0]  max_next;
    logic [otl_pkg::SUM_W:0]     sum_wide;

    assign sum_wide = {1'b0, sum_reg}
                    + {{(otl_pkg::SUM_W + 1 - otl_pkg::TIME_W){1'b0}}, lat};

    always_comb
    begin
        sum_next = sum_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (update)
        begin
            // saturate on carry out of the 48-bit total
            sum_next = sum_wide[otl_pkg::SUM_W] ? {otl_pkg::SUM_W{1'b1}}
                                                : sum_wide[otl_pkg::SUM_W-1:0];
            if (lat < min_reg)
                min_next = lat;
            if (lat > max_reg)
                max_next = lat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign total   = sum_reg;
    assign min_lat = min_reg;
    assign max_lat = max_reg;

endmodule

`default_nettype wire

// File: rtl/outstanding_id_latency_table_core.sv
// Outstanding-ID latency table.
// Input channel (in_valid/in_ready) carries one word: command, key, time_value.
// Commands insert at tail or head, drop the head, or remove the match nearest
// the head; keyed removals report now minus start as latency and,
// with accumulate_enable set, feed a saturating 48-bit total and min/max.
// Output channel (out_valid/out_ready) returns exactly one word per input word.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes accumulate_enable;
// cfg_ready is always high. Write it only while the block is idle.
// The result word passes through match capture, table update and result load
// before it is valid. One word is in flight at a time: a new word is accepted
// only after the last result has loaded; the table is a row of DEPTH cells
// that all compare keys in parallel and shift by one position per update.
// If the receiver stalls, the finished result waits in the output register
// while the next word is already accepted and worked through the table; it
// then holds until the output register frees up.
// Reset (rst_n, async, active low) empties the table, clears total and max,
// sets min to all ones and accumulate_enable to 1. No clearing pass is needed.
`default_nettype none

module outstanding_id_latency_table_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     command,
    input  wire logic signed [31:0]             key,
    input  wire logic [31:0]                    time_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                found,
    output logic                                dropped,
    output logic [31:0]                         latency,
    output logic [4:0]                          entry_count,
    output logic [47:0]                         total_latency,
    output logic [31:0]                         min_latency,
    output logic [31:0]                         max_latency,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;

    // captured input word
    logic [1:0]                    cmd_reg;
    logic [1:0]                    cmd_next;
    logic [otl_pkg::KEY_W-1:0]     key_reg;
    logic [otl_pkg::KEY_W-1:0]     key_next;
    logic [otl_pkg::TIME_W-1:0]    time_reg;
    logic [otl_pkg::TIME_W-1:0]    time_next;

    logic [DEPTH-1:0]              hit_reg;
    logic [DEPTH-1:0]              hit_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;

    // pending result between table update and output load
    logic                          pend_found_reg;
    logic                          pend_found_next;
    logic                          pend_drop_reg;
    logic                          pend_drop_next;
    logic [otl_pkg::TIME_W-1:0]    pend_lat_reg;
    logic [otl_pkg::TIME_W-1:0]    pend_lat_next;
    logic                          pend_acc_reg;
    logic                          pend_acc_next;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          found_reg;
    logic                          found_next;
    logic                          dropped_reg;
    logic                          dropped_next;
    logic [otl_pkg::TIME_W-1:0]    latency_reg;
    logic [otl_pkg::TIME_W-1:0]    latency_next;
    logic [CW-1:0]                 count_out_reg;
    logic [CW-1:0]                 count_out_next;

    logic                          acc_en_reg;

    // cell chain
    otl_pkg::cell_op_t             cell_op;
    logic [DEPTH-1:0]              shl_mask;
    logic [DEPTH-1:0]              cell_hit;
    logic [DEPTH-1:0]              first_hit;
    logic                          any_hit;
    otl_pkg::cell_data_t           cell_q [DEPTH];
    otl_pkg::cell_data_t           head_in;
    otl_pkg::cell_data_t           tail_in;
    logic [otl_pkg::TIME_W-1:0]    sel_start;
    logic                          full;
    logic                          empty;
    logic                          out_free;
    logic                          stats_update;

    assign head_in.valid = 1'b1;
    assign head_in.key   = key_reg;
    assign head_in.start = time_reg;
    assign tail_in       = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            otl_pkg::cell_data_t left_w;
            otl_pkg::cell_data_t right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = head_in;
            end
            else
            begin : g_mid_l
                assign left_w = cell_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = tail_in;
            end
            else
            begin : g_mid_r
                assign right_w = cell_q[gi+1];
            end

            otl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cell_op),
                .shl_en     (shl_mask[gi]),
                .new_key    (key_reg),
                .new_start  (time_reg),
                .search_key (key_reg),
                .left       (left_w),
                .right      (right_w),
                .q          (cell_q[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    // matching entry nearest the head, as a one-hot vector
    assign first_hit = hit_reg & (~hit_reg + {{(DEPTH-1){1'b0}}, 1'b1});
    assign any_hit   = |hit_reg;
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        sel_start = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_start = sel_start | (first_hit[i] ? cell_q[i].start : '0);
        end
    end

    // table operation for this cycle
    always_comb
    begin
        cell_op  = otl_pkg::CELL_HOLD;
        shl_mask = '0;
        if (state_reg == S_APPLY)
        begin
            unique case (cmd_reg)
                otl_pkg::CMD_INSERT_TAIL:
                begin
                    if (!full)
                        cell_op = otl_pkg::CELL_LOAD_TAIL;
                end
                otl_pkg::CMD_INSERT_HEAD:
                begin
                    if (!full)
                        cell_op = otl_pkg::CELL_SHIFT_R;
                end
                otl_pkg::CMD_REMOVE_HEAD:
                begin
                    cell_op  = otl_pkg::CELL_SHIFT_L;
                    shl_mask = '1;
                end
                otl_pkg::CMD_REMOVE_KEY:
                begin
                    // every cell at or beyond the match pulls from its right
                    cell_op  = otl_pkg::CELL_SHIFT_L;
                    shl_mask = any_hit ? ~(first_hit - {{(DEPTH-1){1'b0}}, 1'b1}) : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        time_next       = time_reg;
        hit_next        = hit_reg;
        count_next      = count_reg;
        pend_found_next = pend_found_reg;
        pend_drop_next  = pend_drop_reg;
        pend_lat_next   = pend_lat_reg;
        pend_acc_next   = pend_acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        dropped_next    = dropped_reg;
        latency_next    = latency_reg;
        count_out_next  = count_out_reg;
        stats_update    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    time_next  = time_value;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                hit_next   = cell_hit;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                pend_found_next = 1'b0;
                pend_drop_next  = 1'b0;
                pend_lat_next   = '0;
                pend_acc_next   = 1'b0;
                unique case (cmd_reg)
                    otl_pkg::CMD_INSERT_TAIL,
                    otl_pkg::CMD_INSERT_HEAD:
                    begin
                        if (full)
                            pend_drop_next = 1'b1;
                        else
                            count_next = count_reg + 1'b1;
                    end
                    otl_pkg::CMD_REMOVE_HEAD:
                    begin
                        if (!empty)
                        begin
                            pend_found_next = 1'b1;
                            count_next      = count_reg - 1'b1;
                        end
                    end
                    otl_pkg::CMD_REMOVE_KEY:
                    begin
                        if (any_hit)
                        begin
                            pend_found_next = 1'b1;
                            pend_lat_next   = time_reg - sel_start;
                            pend_acc_next   = acc_en_reg;
                            count_next      = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = pend_found_reg;
                    dropped_next   = pend_drop_reg;
                    latency_next   = pend_lat_reg;
                    count_out_next = count_reg;
                    stats_update   = pend_acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
            key_reg        <= '0;
            time_reg       <= '0;
            hit_reg        <= '0;
            pend_found_reg <= 1'b0;
            pend_drop_reg  <= 1'b0;
            pend_lat_reg   <= '0;
            pend_acc_reg   <= 1'b0;
            found_reg      <= 1'b0;
            dropped_reg    <= 1'b0;
            latency_reg    <= '0;
            count_out_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            time_reg       <= time_next;
            hit_reg        <= hit_next;
            pend_found_reg <= pend_found_next;
            pend_drop_reg  <= pend_drop_next;
            pend_lat_reg   <= pend_lat_next;
            pend_acc_reg   <= pend_acc_next;
            found_reg      <= found_next;
            dropped_reg    <= dropped_next;
            latency_reg    <= latency_next;
            count_out_reg  <= count_out_next;
        end
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            acc_en_reg <= cfg_data;
        end
    end

    // stats only move when a new result loads, so they hold during a stall
    otl_stats u_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .update  (stats_update),
        .lat     (pend_lat_reg),
        .total   (total_latency),
        .min_lat (min_latency),
        .max_lat (max_latency)
    );

    // count to 5-bit port, truncating or zero extending with DEPTH
    genvar gb;
    generate
        for (gb = 0; gb < otl_pkg::COUNT_W; gb++)
        begin : g_cnt
            if (gb < CW)
            begin : g_bit
                assign entry_count[gb] = count_out_reg[gb];
            end
            else
            begin : g_zero
                assign entry_count[gb] = 1'b0;
            end
        end
    endgenerate

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign dropped   = dropped_reg;
    assign latency   = latency_reg;

endmodule

`default_nettype wire

// File: rtl/otl_checker.sv
`default_nettype none

module otl_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire logic           found,
    input  wire logic           dropped,
    input  wire logic [31:0]    latency,
    input  wire logic [31:0]    min_latency,
    input  wire logic [31:0]    max_latency
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(latency))
        else $error("result word changed while stalled");

    // a word never both removes and refuses
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && dropped))
        else $error("found and dropped both set");

    // a nonzero latency only comes with a removal
    a_lat_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (latency != 32'd0) |-> found)
        else $error("latency without removal");

    // once anything is accumulated, min never exceeds max
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (max_latency != 32'd0) |-> min_latency <= max_latency)
        else $error("min latency above max latency");

endmodule

bind outstanding_id_latency_table_core otl_checker u_otl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .dropped     (dropped),
    .latency     (latency),
    .min_latency (min_latency),
    .max_latency (max_latency)
);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH     = 16;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 80;     // long receiver stall, fills the pipe

    // One result word as the block presents it
    typedef struct packed {
        logic        found;
        logic        dropped;
        logic [31:0] latency;
        logic [4:0]  entry_count;
        logic [47:0] total_latency;
        logic [31:0] min_latency;
        logic [31:0] max_latency;
    } reply_t;

    // Mirror of the latency table plus the queue of replies still owed by the block
    class latency_table_scoreboard;
        logic [31:0] slot_key   [TABLE_DEPTH];
        logic [31:0] slot_start [TABLE_DEPTH];
        int unsigned live;
        logic [47:0] sum;
        logic [31:0] lat_min;
        logic [31:0] lat_max;
        bit          accumulate_on;
        reply_t      expected_q [$];
        int unsigned errors;
        int unsigned words;
        int unsigned key_hits;
        int unsigned drops;
        int unsigned checked;

        function new();
            live          = 0;
            sum           = '0;
            lat_min       = '1;
            lat_max       = '0;
            accumulate_on = 1'b1;
            errors        = 0;
            words         = 0;
            key_hits      = 0;
            drops         = 0;
            checked       = 0;
        endfunction

        function void close_gap(int unsigned pos);
            for (int unsigned i = pos; i + 1 < live; i++)
            begin
                slot_key[i]   = slot_key[i + 1];
                slot_start[i] = slot_start[i + 1];
            end
            live--;
        endfunction

        // Called on every accepted input word
        function void note_word(logic [1:0] cmd, logic [31:0] k, logic [31:0] tv);
            reply_t      r;
            int          hit;
            logic [48:0] acc;
            r   = '0;
            hit = -1;
            words++;
            case (cmd)
                otl_pkg::CMD_INSERT_TAIL, otl_pkg::CMD_INSERT_HEAD:
                begin
                    if (live >= TABLE_DEPTH)
                    begin
                        r.dropped = 1'b1;
                        drops++;
                    end
                    else if (cmd == otl_pkg::CMD_INSERT_TAIL)
                    begin
                        slot_key[live]   = k;
                        slot_start[live] = tv;
                        live++;
                    end
                    else
                    begin
                        for (int i = live; i > 0; i--)
                        begin
                            slot_key[i]   = slot_key[i - 1];
                            slot_start[i] = slot_start[i - 1];
                        end
                        slot_key[0]   = k;
                        slot_start[0] = tv;
                        live++;
                    end
                end
                otl_pkg::CMD_REMOVE_HEAD:
                begin
                    if (live > 0)
                    begin
                        close_gap(0);
                        r.found = 1'b1;
                    end
                end
                default:
                begin
                    // the match nearest the head wins when keys repeat
                    for (int i = 0; i < live; i++)
                        if (hit < 0 && slot_key[i] == k)
                            hit = i;
                    if (hit >= 0)
                    begin
                        r.latency = tv - slot_start[hit];
                        if (accumulate_on)
                        begin
                            acc = {1'b0, sum} + {17'd0, r.latency};
                            sum = acc[48] ? '1 : acc[47:0];
                            if (r.latency > lat_max)
                                lat_max = r.latency;
                            if (r.latency < lat_min)
                                lat_min = r.latency;
                        end
                        close_gap(hit);
                        r.found = 1'b1;
                        key_hits++;
                    end
                end
            endcase
            r.entry_count   = live[4:0];
            r.total_latency = sum;
            r.min_latency   = lat_min;
            r.max_latency   = lat_max;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, want, got);
            end
        endfunction

        // Called on every accepted result word
        function void check_reply(reply_t got);
            reply_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, got %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("found",         want.found,         got.found);
            compare_field("dropped",       want.dropped,       got.dropped);
            compare_field("latency",       want.latency,       got.latency);
            compare_field("entry_count",   want.entry_count,   got.entry_count);
            compare_field("total_latency", want.total_latency, got.total_latency);
            compare_field("min_latency",   want.min_latency,   got.min_latency);
            compare_field("max_latency",   want.max_latency,   got.max_latency);
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                errors++;
                $display("%0t: %0d result words never arrived, expected %h, got nothing",
                         $time, expected_q.size(), expected_q[0]);
            end
        endfunction
    endclass

    // DUT-facing signals, all known from time 0
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  command    = otl_pkg::CMD_INSERT_TAIL;
    logic signed [31:0] key = '0;
    logic [31:0] time_value = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        found;
    logic        dropped;
    logic [31:0] latency;
    logic [4:0]  entry_count;
    logic [47:0] total_latency;
    logic [31:0] min_latency;
    logic [31:0] max_latency;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_data   = 1'b0;

    latency_table_scoreboard sb;

    // Idle-mode knobs for the sender and the receiver
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    bit hold_req   = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    outstanding_id_latency_table_core #(
        .DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .key          (key),
        .time_value   (time_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .dropped      (dropped),
        .latency      (latency),
        .entry_count  (entry_count),
        .total_latency(total_latency),
        .min_latency  (min_latency),
        .max_latency  (max_latency),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Offer one word, optionally after a random gap, and hold it until accepted.
    // With a zero gap valid just stays high into the next word.
    task automatic send_word(logic [1:0] cmd, logic [31:0] k, logic [31:0] tv);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        key        <= k;
        time_value <= tv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(cmd, k, tv);
    endtask

    // Sender goes quiet until every owed result word has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // accumulate_enable is only touched with the block idle
    task automatic write_accumulate(logic v);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.accumulate_on = v;
        cfg_valid <= 1'b0;
    endtask

    // Small key pool so duplicates and hits are common; some fully random keys
    function automatic logic [31:0] pool_key();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) | $urandom_range(0, 7);
    endfunction

    // Random traffic that swings between filling and draining the table,
    // so both the full and the empty corners get hit. A few noise words mixed in.
    task automatic send_random(int n);
        logic [1:0]  cmd;
        logic [31:0] k;
        logic [31:0] tv;
        int          roll;
        bit          filling;
        filling = 1'b1;
        for (int j = 0; j < n; j++)
        begin
            if (j > 0 && j % 30 == 0)
            begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (sb.live == TABLE_DEPTH && $urandom_range(0, 3) != 0)
                filling = 1'b0;
            if (sb.live == 0 && $urandom_range(0, 3) != 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            tv   = $urandom;
            if (roll < 8)
            begin
                cmd = 2'($urandom_range(0, 3));
                k   = $urandom;
            end
            else if (filling ? (roll < 75) : (roll >= 75))
            begin
                cmd = $urandom_range(0, 1) ? otl_pkg::CMD_INSERT_HEAD
                                           : otl_pkg::CMD_INSERT_TAIL;
                k   = pool_key();
            end
            else
            begin
                cmd = (roll % 4 == 0) ? otl_pkg::CMD_REMOVE_HEAD : otl_pkg::CMD_REMOVE_KEY;
                if (sb.live > 0 && $urandom_range(0, 4) != 0)
                    k = sb.slot_key[$urandom_range(0, sb.live - 1)];
                else
                    k = pool_key();
            end
            send_word(cmd, k, tv);
        end
    endtask

    // Receiver: random stall per word, or one long hold-off on request
    initial
    begin : result_sink
        int     stall;
        reply_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall    = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = rx_gaps_on ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.found         = found;
            got.dropped       = dropped;
            got.latency       = latency;
            got.entry_count   = entry_count;
            got.total_latency = total_latency;
            got.min_latency   = min_latency;
            got.max_latency   = max_latency;
            sb.check_reply(got);
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, accumulate at its reset value of 1
        send_word(otl_pkg::CMD_REMOVE_HEAD, 32'h0, 32'h0);          // head drop on empty
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'h0, 32'h0);          // keyed miss on empty
        send_word(otl_pkg::CMD_INSERT_TAIL, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(otl_pkg::CMD_INSERT_HEAD, 32'h7FFF_FFFF, 32'h0);
        send_word(otl_pkg::CMD_INSERT_TAIL, 32'h0, 32'd5);
        send_word(otl_pkg::CMD_INSERT_TAIL, 32'h8000_0000, 32'd100); // duplicate key
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'h8000_0000, 32'h10);  // oldest dup, time wraps
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'h8000_0000, 32'hFFFF_FFFF);
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'h1234_5678, 32'h0);   // keyed miss
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'h7FFF_FFFF, 32'hFFFF_FFFF); // max latency
        send_word(otl_pkg::CMD_INSERT_HEAD, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'hFFFF_FFFF, 32'hAAAA_AAAA); // zero latency
        send_word(otl_pkg::CMD_REMOVE_HEAD, 32'h0, 32'h0);          // head drop, latency output cleared
        send_word(otl_pkg::CMD_REMOVE_HEAD, 32'h0, 32'h0);
        send_word(otl_pkg::CMD_INSERT_TAIL, 32'h5555_5555, 32'h5555_5555);
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'h5555_5555, 32'hAAAA_AAAA);

        // Accumulation off: hits report latency but totals stay put
        write_accumulate(1'b0);
        send_word(otl_pkg::CMD_INSERT_TAIL, 32'd42, 32'd7);
        send_word(otl_pkg::CMD_REMOVE_KEY,  32'd42, 32'd1000);
        send_random(100);

        write_accumulate(1'b1);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_random(100);

        // Long receiver hold-off with the sender pushing back to back
        hold_req   = 1'b1;
        tx_gaps_on = 1'b0;
        send_random(20);
        pause_until_drained();

        tx_gaps_on = 1'b1;
        send_random(60);
        write_accumulate(1'b0);
        send_random(40);
        write_accumulate(1'b1);

        // Fill to the brim (last insert is refused), then empty via head drops
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        repeat (TABLE_DEPTH + 1)
            send_word($urandom_range(0, 1) ? otl_pkg::CMD_INSERT_HEAD
                                           : otl_pkg::CMD_INSERT_TAIL,
                      pool_key(), $urandom);
        while (sb.live != 0)
            send_word(otl_pkg::CMD_REMOVE_HEAD, $urandom, $urandom);

        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_random(40);

        pause_until_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        sb.close_out();

        $display("Covered %0d words with %0d keyed hits and %0d refused inserts; %0d checked.",
                 sb.words, sb.key_hits, sb.drops, sb.checked);
        $display("Accumulate toggled, table filled and drained, long output stall; %0d errors.",
                 sb.errors);
        if (sb.errors == 0)
            $display("outstanding_id_latency_table_core verification clean");
        else
            $display("outstanding_id_latency_table_core verification failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin
        #200_000;
        $display("Timeout: handshake stuck or results missing");
        $display("outstanding_id_latency_table_core verification failed");
        $finish;
    end

endmodule
